// File: hdl/bundle_container_deframer_top_defines.svh
// ----------------------------------------------------------------------------
// bundle container deframer assertion macros
// shared assertion helpers for the deframer rtl; empty under synthesis
// ----------------------------------------------------------------------------
`ifndef BUNDLE_CONTAINER_DEFRAMER_TOP_DEFINES_SVH
`define BUNDLE_CONTAINER_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define BCD_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("bcd assertion failed");

// consequent holds in the cycle after the antecedent
`define BCD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcd assertion failed");

`else

`define BCD_ASSERT(lbl, cond)
`define BCD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg
// phase, segment and status codes and header constants of the bundle deframer
// ----------------------------------------------------------------------------
package bcd_pkg;

	typedef logic [3:0] phase_t;
	typedef logic [2:0] seg_t;
	typedef logic [3:0] status_t;

	localparam int IV_BYTES_DEF  = 12;
	localparam int TAG_BYTES_DEF = 16;

	localparam phase_t PH_MAGIC   = 4'd0;
	localparam phase_t PH_VERSION = 4'd1;
	localparam phase_t PH_LENK    = 4'd2;
	localparam phase_t PH_KEY     = 4'd3;
	localparam phase_t PH_IV      = 4'd4;
	localparam phase_t PH_TAG     = 4'd5;
	localparam phase_t PH_LENC    = 4'd6;
	localparam phase_t PH_CT      = 4'd7;
	localparam phase_t PH_TRAIL   = 4'd8;
	localparam phase_t PH_ERR     = 4'd9;

	localparam seg_t SEG_HDR   = 3'd0;
	localparam seg_t SEG_KEY   = 3'd1;
	localparam seg_t SEG_IV    = 3'd2;
	localparam seg_t SEG_TAG   = 3'd3;
	localparam seg_t SEG_CT    = 3'd4;
	localparam seg_t SEG_TRAIL = 3'd5;

	localparam status_t ST_BUSY        = 4'd0;
	localparam status_t ST_COMPLETE    = 4'd1;
	localparam status_t ST_BAD_MAGIC   = 4'd2;
	localparam status_t ST_BAD_VERSION = 4'd3;
	localparam status_t ST_UNDER_BASE  = 4'd2;

	localparam logic [7:0] VERSION_BYTE = 8'h01;

	localparam logic [2:0] MAGIC_LAST = 3'd3;
	localparam logic [2:0] LENK_LAST  = 3'd3;
	localparam logic [2:0] LENC_LAST  = 3'd7;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h48;
			2'd1: b = 8'h43;
			2'd2: b = 8'h52;
			default: b = 8'h59;
		endcase
		return b;
	endfunction

	function automatic seg_t phase_segment(input phase_t ph);
		seg_t s;
		case (ph)
			PH_MAGIC, PH_VERSION, PH_LENK, PH_LENC: s = SEG_HDR;
			PH_KEY: s = SEG_KEY;
			PH_IV:  s = SEG_IV;
			PH_TAG: s = SEG_TAG;
			PH_CT:  s = SEG_CT;
			default: s = SEG_TRAIL;
		endcase
		return s;
	endfunction

endpackage

// File: hdl/bundle_container_deframer_top.sv
// ----------------------------------------------------------------------------
// bundle_container_deframer_top
// byte-stream parser that tags every beat of an encrypted bundle container
// ----------------------------------------------------------------------------
// Each input beat is one bundle byte plus a last flag and produces exactly one
// output beat: the byte, its segment (header/length, key, iv, tag, ciphertext,
// trailing) and a status (busy, complete, bad magic, bad version, or underflow
// naming the section still expected when the last byte arrives early). The
// block sustains one beat per clock while out_ready is high; a beat passes an
// input register followed by a result register, and the per-byte work is one
// phase update with a 64-bit run counter decrement and zero compare. After a
// beat marked last the parser returns to its reset state for the next bundle.
`include "bundle_container_deframer_top_defines.svh"

module bundle_container_deframer_top
	import bcd_pkg::*;
#(
	parameter int IV_BYTES  = IV_BYTES_DEF,
	parameter int TAG_BYTES = TAG_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] segment,
	output logic [3:0] status,
	output logic       out_last
);

	logic        v1_q;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        v2_q;
	logic [7:0]  byte_s2;
	seg_t        seg_s2;
	status_t     status_s2;
	logic        last_s2;

	phase_t      phase_q;
	logic [2:0]  idx_q;
	logic [63:0] cnt_q;
	logic [63:0] len_q;
	logic [1:0]  err_q;

	phase_t      nxt_phase;
	logic [2:0]  nxt_idx;
	logic [63:0] nxt_cnt;
	logic [63:0] nxt_len;
	logic [1:0]  nxt_err;
	logic        err_now;
	seg_t        seg_c;
	status_t     status_c;
	logic [63:0] cnt_dec;
	logic        cnt_zero;
	logic [63:0] len_shift;
	logic        adv1;

	assign adv1     = v1_q && (!v2_q || out_ready);
	assign in_ready = !v1_q || adv1;

	assign cnt_dec   = cnt_q - 64'd1;
	assign cnt_zero  = (cnt_dec == 64'd0);
	assign len_shift = {len_q[55:0], byte_s1};

	always_comb begin
		nxt_phase = phase_q;
		nxt_idx   = idx_q;
		nxt_cnt   = cnt_q;
		nxt_len   = len_q;
		nxt_err   = err_q;
		err_now   = 1'b0;
		seg_c     = phase_segment(phase_q);
		case (phase_q)
			PH_MAGIC: begin
				if (byte_s1 != magic_byte(idx_q[1:0])) begin
					nxt_err   = ST_BAD_MAGIC[1:0];
					err_now   = 1'b1;
					nxt_phase = PH_ERR;
				end else if (idx_q == MAGIC_LAST) begin
					nxt_idx   = 3'd0;
					nxt_phase = PH_VERSION;
				end else begin
					nxt_idx = idx_q + 3'd1;
				end
			end
			PH_VERSION: begin
				if (byte_s1 != VERSION_BYTE) begin
					nxt_err   = ST_BAD_VERSION[1:0];
					err_now   = 1'b1;
					nxt_phase = PH_ERR;
				end else begin
					nxt_idx   = 3'd0;
					nxt_len   = 64'd0;
					nxt_phase = PH_LENK;
				end
			end
			PH_LENK: begin
				nxt_len = len_shift;
				if (idx_q == LENK_LAST) begin
					nxt_idx = 3'd0;
					if (len_shift[31:0] != 32'd0) begin
						nxt_cnt   = {32'd0, len_shift[31:0]};
						nxt_phase = PH_KEY;
					end else begin
						nxt_cnt   = 64'(IV_BYTES);
						nxt_phase = PH_IV;
					end
				end else begin
					nxt_idx = idx_q + 3'd1;
				end
			end
			PH_LENC: begin
				nxt_len = len_shift;
				if (idx_q == LENC_LAST) begin
					nxt_idx   = 3'd0;
					nxt_cnt   = len_shift;
					nxt_phase = (len_shift != 64'd0) ? PH_CT : PH_TRAIL;
				end else begin
					nxt_idx = idx_q + 3'd1;
				end
			end
			PH_KEY: begin
				nxt_cnt = cnt_dec;
				if (cnt_zero) begin
					nxt_cnt   = 64'(IV_BYTES);
					nxt_phase = PH_IV;
				end
			end
			PH_IV: begin
				nxt_cnt = cnt_dec;
				if (cnt_zero) begin
					nxt_cnt   = 64'(TAG_BYTES);
					nxt_phase = PH_TAG;
				end
			end
			PH_TAG: begin
				nxt_cnt = cnt_dec;
				if (cnt_zero) begin
					nxt_len   = 64'd0;
					nxt_idx   = 3'd0;
					nxt_phase = PH_LENC;
				end
			end
			PH_CT: begin
				nxt_cnt = cnt_dec;
				if (cnt_zero) begin
					nxt_phase = PH_TRAIL;
				end
			end
			PH_TRAIL: begin
				nxt_phase = PH_TRAIL;
			end
			default: begin
				nxt_phase = PH_ERR;
			end
		endcase

		if (err_now || nxt_phase == PH_ERR) begin
			status_c = {2'b00, nxt_err};
		end else if (nxt_phase == PH_TRAIL) begin
			status_c = ST_COMPLETE;
		end else if (last_s1) begin
			status_c = {1'b0, nxt_phase[2:0]} + ST_UNDER_BASE;
		end else begin
			status_c = ST_BUSY;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			v1_q <= 1'b1;
		end else if (adv1) begin
			v1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// parser state, returns to reset after a last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			idx_q   <= 3'd0;
			cnt_q   <= 64'd0;
			len_q   <= 64'd0;
			err_q   <= 2'd0;
		end else if (adv1) begin
			if (last_s1) begin
				phase_q <= PH_MAGIC;
				idx_q   <= 3'd0;
				cnt_q   <= 64'd0;
				len_q   <= 64'd0;
				err_q   <= 2'd0;
			end else begin
				phase_q <= nxt_phase;
				idx_q   <= nxt_idx;
				cnt_q   <= nxt_cnt;
				len_q   <= nxt_len;
				err_q   <= nxt_err;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q <= 1'b0;
		end else if (adv1) begin
			v2_q <= 1'b1;
		end else if (out_ready) begin
			v2_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			byte_s2   <= byte_s1;
			seg_s2    <= seg_c;
			status_s2 <= status_c;
			last_s2   <= last_s1;
		end
	end

	assign out_valid = v2_q;
	assign out_byte  = byte_s2;
	assign segment   = seg_s2;
	assign status    = status_s2;
	assign out_last  = last_s2;

	`BCD_ASSERT(a_phase_range, phase_q <= PH_ERR)
	`BCD_ASSERT(a_err_latched, (phase_q != PH_ERR) || (err_q != 2'd0))
	`BCD_ASSERT(a_run_nonzero, ((phase_q != PH_KEY) && (phase_q != PH_CT)) || (cnt_q != 64'd0))
	`BCD_ASSERT_NEXT(a_last_resets, adv1 && last_s1, (phase_q == PH_MAGIC) && (err_q == 2'd0))
	`BCD_ASSERT(a_empty_ready, v1_q || in_ready)

endmodule

// File: tb/bcd_beat_checker.sv
// ----------------------------------------------------------------------------
// bcd_beat_checker
// predicts the tag of every deframer beat and compares it with the output
// ----------------------------------------------------------------------------
// Watches both channels of the bundle deframer. Every accepted input beat is
// run through a local model of the container parser (magic, version, key
// length, key, iv, tag, ciphertext length, ciphertext, trailing, error) and
// the expected output beat is queued. Every accepted output beat is compared
// field by field with the oldest queued beat. The failure count and the
// number of beats still awaited are handed to the testbench top.
`timescale 1ns / 100ps

module bcd_beat_checker
	import bcd_pkg::*;
#(
	parameter int IV_BYTES  = IV_BYTES_DEF,
	parameter int TAG_BYTES = TAG_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic [2:0] segment,
	input  logic [3:0] status,
	input  logic       out_last,
	output int         fails,
	output int         pending
);

	localparam logic [31:0] MAGIC_WORD = 32'h48435259;

	typedef struct packed {
		logic [7:0] data;
		seg_t       seg;
		status_t    st;
		logic       last;
	} beat_tag_t;

	phase_t      ph       = PH_MAGIC;
	logic [63:0] run_cnt  = '0;
	logic [63:0] len_acc  = '0;
	status_t     err_code = ST_BUSY;
	beat_tag_t   tag_queue[$];

	function automatic seg_t segment_of(input phase_t p);
		seg_t s;
		case (p)
			PH_MAGIC, PH_VERSION, PH_LENK, PH_LENC: s = SEG_HDR;
			PH_KEY: s = SEG_KEY;
			PH_IV: s = SEG_IV;
			PH_TAG: s = SEG_TAG;
			PH_CT: s = SEG_CT;
			default: s = SEG_TRAIL;
		endcase
		return s;
	endfunction

	function automatic beat_tag_t deframe_byte(input logic [7:0] b, input logic l);
		beat_tag_t t;
		t.data = b;
		t.last = l;
		t.seg  = segment_of(ph);
		t.st   = ST_BUSY;
		case (ph)
			PH_MAGIC: begin
				if (b != MAGIC_WORD[8 * (3 - run_cnt[1:0]) +: 8]) begin
					err_code = ST_BAD_MAGIC;
					ph = PH_ERR;
				end else if (run_cnt == 64'd3) begin
					run_cnt = '0;
					ph = PH_VERSION;
				end else begin
					run_cnt++;
				end
			end
			PH_VERSION: begin
				if (b != VERSION_BYTE) begin
					err_code = ST_BAD_VERSION;
					ph = PH_ERR;
				end else begin
					run_cnt = '0;
					len_acc = '0;
					ph = PH_LENK;
				end
			end
			PH_LENK, PH_LENC: begin
				len_acc = {len_acc[55:0], b};
				run_cnt++;
				if (ph == PH_LENK && run_cnt >= 64'd4) begin
					run_cnt = {32'd0, len_acc[31:0]};
					if (run_cnt == '0) begin
						run_cnt = 64'(IV_BYTES);
						ph = PH_IV;
					end else begin
						ph = PH_KEY;
					end
				end else if (ph == PH_LENC && run_cnt >= 64'd8) begin
					run_cnt = len_acc;
					ph = (run_cnt != '0) ? PH_CT : PH_TRAIL;
				end
			end
			PH_KEY: begin
				run_cnt--;
				if (run_cnt == '0) begin
					run_cnt = 64'(IV_BYTES);
					ph = PH_IV;
				end
			end
			PH_IV: begin
				run_cnt--;
				if (run_cnt == '0) begin
					run_cnt = 64'(TAG_BYTES);
					ph = PH_TAG;
				end
			end
			PH_TAG: begin
				run_cnt--;
				if (run_cnt == '0) begin
					len_acc = '0;
					ph = PH_LENC;
				end
			end
			PH_CT: begin
				run_cnt--;
				if (run_cnt == '0) begin
					ph = PH_TRAIL;
				end
			end
			default: ;
		endcase
		if (ph == PH_ERR) begin
			t.st = err_code;
		end else if (ph == PH_TRAIL) begin
			t.st = ST_COMPLETE;
		end else if (l) begin
			t.st = ST_UNDER_BASE + status_t'(ph);
		end
		if (l) begin
			ph       = PH_MAGIC;
			run_cnt  = '0;
			len_acc  = '0;
			err_code = ST_BUSY;
		end
		return t;
	endfunction

	always @(posedge clk) begin
		beat_tag_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				tag_queue = {tag_queue, deframe_byte(in_byte, in_last)};
			end
			if (out_valid && out_ready) begin
				if (tag_queue.size() == 0) begin
					$error("out_byte: expected no beat, actual %0h", out_byte);
					fails++;
				end else begin
					want = tag_queue.pop_front();
					if (out_byte !== want.data) begin
						$error("out_byte: expected %0h, actual %0h", want.data, out_byte);
						fails++;
					end
					if (segment !== want.seg) begin
						$error("segment: expected %0d, actual %0d", want.seg, segment);
						fails++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, actual %0d", want.st, status);
						fails++;
					end
					if (out_last !== want.last) begin
						$error("out_last: expected %0d, actual %0d", want.last, out_last);
						fails++;
					end
				end
			end
			pending = tag_queue.size();
		end
	end

endmodule

// File: tb/tb_bundle_container_deframer_top.sv
// ----------------------------------------------------------------------------
// tb_bundle_container_deframer_top
// stimulus and verdict for the bundle container deframer
// ----------------------------------------------------------------------------
// Sends a few short directed header cases, then random bundles: whole ones
// with zero, small and long key and ciphertext runs plus trailing bytes,
// bundles cut short anywhere (some with huge declared lengths), corrupted
// magic or version, and plain noise. Both channels stall at random, with a
// stretch of no stalls and one full drain pause. The checker predicts and
// compares every output beat; a watchdog ends a stuck run.
`timescale 1ns / 100ps

module tb_bundle_container_deframer_top;
	import bcd_pkg::*;

	localparam int BEAT_TARGET    = 900;
	localparam int CALM_FIRST     = 300;
	localparam int CALM_LAST      = 450;
	localparam int PAUSE_AT       = 600;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 10;
	localparam int IDLE_PCT       = 11;

	localparam logic [31:0] MAGIC_WORD = 32'h48435259;

	typedef enum int {BK_WHOLE, BK_CUT, BK_BAD_HDR, BK_NOISE} bundle_kind_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte   = '0;
	logic       in_last   = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic [2:0] segment;
	logic [3:0] status;
	logic       out_last;

	int         fails;
	int         pending;
	int         beats_sent  = 0;
	int         directed    = 0;
	int         idle_cycles = 0;
	int         kind_count[4] = '{default: 0};
	bit         calm   = 1'b0;
	bit         paused = 1'b0;
	logic [7:0] frame[$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	bundle_container_deframer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.segment   (segment),
		.status    (status),
		.out_last  (out_last)
	);

	bcd_beat_checker beat_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.segment   (segment),
		.status    (status),
		.out_last  (out_last),
		.fails     (fails),
		.pending   (pending)
	);

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("bundle_container_deframer_top: mismatch");
				$finish;
			end
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic l);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= l;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		calm = (beats_sent >= CALM_FIRST) && (beats_sent < CALM_LAST);
		@(negedge clk);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame.size(); i++) begin
			send_beat(frame[i], i == frame.size() - 1);
		end
	endtask

	task automatic push_field(input logic [63:0] v, input int n);
		for (int i = n - 1; i >= 0; i--) begin
			frame = {frame, v[8 * i +: 8]};
		end
	endtask

	task automatic push_random(input int n);
		repeat (n) frame = {frame, 8'($urandom)};
	endtask

	task automatic build_whole(input bit wild_len);
		logic [31:0] klen;
		logic [63:0] clen;
		int          key_run;
		int          ct_run;
		case ($urandom_range(0, 19))
			0, 1, 2, 3: key_run = 0;
			19: key_run = $urandom_range(64, 200);
			default: key_run = $urandom_range(1, 12);
		endcase
		case ($urandom_range(0, 19))
			0, 1, 2, 3: ct_run = 0;
			19: ct_run = $urandom_range(100, 300);
			default: ct_run = $urandom_range(1, 24);
		endcase
		klen = 32'(key_run);
		clen = 64'(ct_run);
		if (wild_len && $urandom_range(0, 1)) klen = $urandom;
		if (wild_len && $urandom_range(0, 1)) clen = {$urandom, $urandom};
		push_field(64'(MAGIC_WORD), 4);
		frame = {frame, VERSION_BYTE};
		push_field(64'(klen), 4);
		push_random(key_run);
		push_random(IV_BYTES_DEF);
		push_random(TAG_BYTES_DEF);
		push_field(clen, 8);
		push_random(ct_run);
		push_random($urandom_range(0, 3));
	endtask

	initial begin
		bundle_kind_t kind;
		int           r;
		int           n;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// short header cases: bad first byte, unfinished magic, bad version,
		// missing version, all-ones key length cut in the key
		frame = '{8'h00};
		send_frame();
		frame = '{8'h48, 8'h43};
		send_frame();
		frame = '{8'h48, 8'h43, 8'h52, 8'h59, 8'h02, 8'hAA};
		send_frame();
		frame = '{8'h48, 8'h43, 8'h52, 8'h59};
		send_frame();
		frame = '{8'h48, 8'h43, 8'h52, 8'h59, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80};
		send_frame();
		directed = 5;

		while (beats_sent < BEAT_TARGET) begin
			r = $urandom_range(0, 99);
			kind = (r < 45) ? BK_WHOLE : (r < 75) ? BK_CUT : (r < 90) ? BK_BAD_HDR : BK_NOISE;
			frame.delete();
			case (kind)
				BK_WHOLE: build_whole(1'b0);
				BK_CUT: begin
					build_whole(1'b1);
					n = $urandom_range(1, frame.size() - 1);
					while (frame.size() > n) frame.pop_back();
				end
				BK_BAD_HDR: begin
					push_field(64'(MAGIC_WORD), 4);
					frame = {frame, VERSION_BYTE};
					n = $urandom_range(0, 4);
					frame[n] = frame[n] ^ 8'($urandom_range(1, 255));
					push_random($urandom_range(0, 10));
				end
				default: push_random($urandom_range(1, 8));
			endcase
			send_frame();
			kind_count[kind]++;
			if (!paused && beats_sent >= PAUSE_AT) begin
				in_valid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
				paused = 1'b1;
			end
		end
		in_valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d beats, %0d directed bundles, %0d whole, %0d cut short,",
			beats_sent, directed, kind_count[BK_WHOLE], kind_count[BK_CUT]);
		$display("     %0d bad magic or version, %0d noise; stalls on both sides, one drain",
			kind_count[BK_BAD_HDR], kind_count[BK_NOISE]);
		if (fails == 0) begin
			$display("bundle_container_deframer_top: match");
		end else begin
			$display("bundle_container_deframer_top: mismatch");
		end
		$finish;
	end

endmodule
